[rtl/ier_pkg.sv]
// ----------------------------------------------------------------------------
// ier_pkg
// Shared constants, types and helpers for the ICMP echo responder.
// ----------------------------------------------------------------------------
package ier_pkg;

  localparam int HDR_LEN = 42;
  localparam int MAC_LEN = 6;
  localparam int CNT_W   = 6;

  localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP      = 8'd1;
  localparam logic [7:0]  ICMP_TYPE_REQ   = 8'd8;
  localparam logic [7:0]  ICMP_TYPE_REPLY = 8'd0;

  // verdict codes
  localparam logic [1:0] VERDICT_PASS = 2'd0;
  localparam logic [1:0] VERDICT_DROP = 2'd1;
  localparam logic [1:0] VERDICT_TX   = 2'd2;

  // header byte positions
  localparam int IDX_ETYPE_HI  = 12;
  localparam int IDX_ETYPE_LO  = 13;
  localparam int IDX_PROTO     = 23;
  localparam int IDX_SRC_IP    = 26;
  localparam int IDX_DST_IP    = 30;
  localparam int IDX_ICMP_TYPE = 34;
  localparam int IDX_CK_HI     = 36;
  localparam int IDX_CK_LO     = 37;
  localparam int IP_ALEN       = 4;

  // minimum lengths for each stage of the verdict
  localparam int MIN_ETH = 14;
  localparam int MIN_IP  = 34;

  typedef logic [HDR_LEN-1:0][7:0] hdr_vec_t;

  typedef struct packed {
    logic [7:0] etype_hi;
    logic [7:0] etype_lo;
    logic [7:0] proto;
    logic [7:0] icmp_type;
    logic [7:0] ck_hi;
    logic [7:0] ck_lo;
  } hdr_fields_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] ck_new;
  } judge_t;

  typedef struct packed {
    logic shift_en;
    logic load_en;
  } chain_ctrl_t;

  // Source header byte for output byte j of an echo reply (address swaps).
  function automatic int src_of(input int j);
    int s;
    s = j;
    if (j < MAC_LEN)
      s = j + MAC_LEN;
    else if (j < 2 * MAC_LEN)
      s = j - MAC_LEN;
    else if (j >= IDX_SRC_IP && j < IDX_DST_IP)
      s = j + IP_ALEN;
    else if (j >= IDX_DST_IP && j < IDX_DST_IP + IP_ALEN)
      s = j - IP_ALEN;
    return s;
  endfunction

endpackage

[rtl/ier_intf.sv]
// ----------------------------------------------------------------------------
// ier_intf
// Valid/ready channels of the ICMP echo responder: frame bytes in and out.
// ----------------------------------------------------------------------------
interface ier_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source(output valid, data_byte, frame_end, input ready);
  modport sink(input valid, data_byte, frame_end, output ready);
endinterface

interface ier_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_end;
  logic [1:0] verdict;

  modport source(output valid, out_byte, out_end, verdict, input ready);
  modport sink(input valid, out_byte, out_end, verdict, output ready);
endinterface

[rtl/icmp_echo_responder.sv]
// Sequence: a header is filled, judged, aligned by shifts and drained before
//   the next frame is taken; bytes past the 42nd stream at one per cycle
//   while the output is not stalled.
// Reset: synchronous, active low; returns to header fill with an empty
//   output register. The header cells are not reset.
// ----------------------------------------------------------------------------
// icmp_echo_responder
// Buffers the first 42 bytes of an Ethernet frame in a chain of byte cells,
// judges it (pass, drop or echo reply) and emits the bytes with the verdict,
// rewriting an ICMP echo request into an echo reply in place.
// ----------------------------------------------------------------------------
module icmp_echo_responder
  import ier_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ier_in_if.sink       in_ch,
  ier_out_if.source    out_ch
);

  // Sequencer states
  localparam logic [2:0] ST_FILL   = 3'd0; // header bytes shift into the chain
  localparam logic [2:0] ST_JUDGE  = 3'd1; // verdict, in-place reply rewrite
  localparam logic [2:0] ST_ALIGN  = 3'd2; // short header: move byte 0 to the top
  localparam logic [2:0] ST_DRAIN  = 3'd3; // header out of the top cell
  localparam logic [2:0] ST_STREAM = 3'd4; // rest of a long frame passes through

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;       // held header bytes
  logic [CNT_W-1:0] skip_r, skip_nxt;     // align shifts still to go
  logic             last_r, last_nxt;     // header ended the frame
  logic [1:0]       verdict_r, verdict_nxt;
  hdr_fields_t      fields_r, fields_nxt;

  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_end_r, out_end_nxt;
  logic [1:0]       out_verdict_r, out_verdict_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             in_xfer;
  logic             out_free;
  chain_ctrl_t      chain_ctrl;
  hdr_vec_t         cells;
  hdr_vec_t         load_vec;
  judge_t           jres;

  assign out_free = !out_valid_r || out_ch.ready;

  // Input is taken while filling the header, and while streaming when the
  // output register can take the byte.
  assign in_ch.ready = (state_r == ST_FILL) || ((state_r == ST_STREAM) && out_free);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  ier_judge u_judge (
    .n   (cnt_r),
    .f   (fields_r),
    .res (jres)
  );

  // Echo reply rewrite. With a full header, byte j sits in cell HDR_LEN-1-j.
  genvar j;
  generate
    for (j = 0; j < HDR_LEN; j++) begin : g_rw
      localparam int Src = src_of(j);
      if (j == IDX_ICMP_TYPE) begin : g_type
        assign load_vec[HDR_LEN-1-j] = ICMP_TYPE_REPLY;
      end else if (j == IDX_CK_HI) begin : g_ckh
        assign load_vec[HDR_LEN-1-j] = jres.ck_new[15:8];
      end else if (j == IDX_CK_LO) begin : g_ckl
        assign load_vec[HDR_LEN-1-j] = jres.ck_new[7:0];
      end else begin : g_move
        assign load_vec[HDR_LEN-1-j] = cells[HDR_LEN-1-Src];
      end
    end
  endgenerate

  ier_chain u_chain (
    .clk      (clk),
    .ctrl     (chain_ctrl),
    .shift_in (in_ch.data_byte),
    .load_vec (load_vec),
    .cells    (cells)
  );

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    skip_nxt        = skip_r;
    last_nxt        = last_r;
    verdict_nxt     = verdict_r;
    fields_nxt      = fields_r;
    out_byte_nxt    = out_byte_r;
    out_end_nxt     = out_end_r;
    out_verdict_nxt = out_verdict_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    chain_ctrl      = '0;

    unique case (state_r)
      ST_FILL: begin
        if (in_xfer) begin
          chain_ctrl.shift_en = 1'b1;
          // capture the fields the verdict and checksum need
          if (cnt_r == CNT_W'(IDX_ETYPE_HI))  fields_nxt.etype_hi  = in_ch.data_byte;
          if (cnt_r == CNT_W'(IDX_ETYPE_LO))  fields_nxt.etype_lo  = in_ch.data_byte;
          if (cnt_r == CNT_W'(IDX_PROTO))     fields_nxt.proto     = in_ch.data_byte;
          if (cnt_r == CNT_W'(IDX_ICMP_TYPE)) fields_nxt.icmp_type = in_ch.data_byte;
          if (cnt_r == CNT_W'(IDX_CK_HI))     fields_nxt.ck_hi     = in_ch.data_byte;
          if (cnt_r == CNT_W'(IDX_CK_LO))     fields_nxt.ck_lo     = in_ch.data_byte;
          cnt_nxt = cnt_r + 1'b1;
          if (in_ch.frame_end || (cnt_r == CNT_W'(HDR_LEN - 1))) begin
            last_nxt  = in_ch.frame_end;
            state_nxt = ST_JUDGE;
          end
        end
      end

      ST_JUDGE: begin
        verdict_nxt        = jres.verdict;
        // a transmit verdict implies a full header, so the layout is fixed
        chain_ctrl.load_en = (jres.verdict == VERDICT_TX);
        skip_nxt           = CNT_W'(HDR_LEN) - cnt_r;
        state_nxt          = (cnt_r == CNT_W'(HDR_LEN)) ? ST_DRAIN : ST_ALIGN;
      end

      ST_ALIGN: begin
        chain_ctrl.shift_en = 1'b1;
        skip_nxt            = skip_r - 1'b1;
        if (skip_r == CNT_W'(1)) state_nxt = ST_DRAIN;
      end

      ST_DRAIN: begin
        if (out_free) begin
          chain_ctrl.shift_en = 1'b1;
          out_valid_nxt       = 1'b1;
          out_byte_nxt        = cells[HDR_LEN-1];
          out_end_nxt         = last_r && (cnt_r == CNT_W'(1));
          out_verdict_nxt     = verdict_r;
          cnt_nxt             = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = last_r ? ST_FILL : ST_STREAM;
            if (last_r) verdict_nxt = VERDICT_PASS;
          end
        end
      end

      ST_STREAM: begin
        if (in_xfer) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = in_ch.data_byte;
          out_end_nxt     = in_ch.frame_end;
          out_verdict_nxt = verdict_r;
          if (in_ch.frame_end) begin
            verdict_nxt = VERDICT_PASS;
            state_nxt   = ST_FILL;
          end
        end
      end

      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cnt_r       <= '0;
      skip_r      <= '0;
      last_r      <= 1'b0;
      verdict_r   <= VERDICT_PASS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      skip_r      <= skip_nxt;
      last_r      <= last_nxt;
      verdict_r   <= verdict_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    fields_r      <= fields_nxt;
    out_byte_r    <= out_byte_nxt;
    out_end_r     <= out_end_nxt;
    out_verdict_r <= out_verdict_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_end  = out_end_r;
  assign out_ch.verdict  = out_verdict_r;

endmodule

[rtl/ier_cell.sv]
// ----------------------------------------------------------------------------
// ier_cell
// One byte cell of the header chain: parallel load or shift from neighbor.
// ----------------------------------------------------------------------------
module ier_cell
  import ier_pkg::*;
(
  input  logic        clk,
  input  chain_ctrl_t ctrl,
  input  logic [7:0]  shift_in,
  input  logic [7:0]  load_val,
  output logic [7:0]  q
);

  logic [7:0] q_r;

  always_ff @(posedge clk) begin
    if (ctrl.load_en) begin
      q_r <= load_val;
    end else if (ctrl.shift_en) begin
      q_r <= shift_in;
    end
  end

  assign q = q_r;

endmodule

[rtl/ier_chain.sv]
// ----------------------------------------------------------------------------
// ier_chain
// Row of header cells. Bytes enter at cell 0 and move toward the top cell.
// ----------------------------------------------------------------------------
module ier_chain
  import ier_pkg::*;
(
  input  logic        clk,
  input  chain_ctrl_t ctrl,
  input  logic [7:0]  shift_in,
  input  hdr_vec_t    load_vec,
  output hdr_vec_t    cells
);

  genvar k;
  generate
    for (k = 0; k < HDR_LEN; k++) begin : g_cell
      if (k == 0) begin : g_head
        ier_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .shift_in (shift_in),
          .load_val (load_vec[k]),
          .q        (cells[k])
        );
      end else begin : g_body
        ier_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .shift_in (cells[k-1]),
          .load_val (load_vec[k]),
          .q        (cells[k])
        );
      end
    end
  endgenerate

endmodule

[rtl/ier_judge.sv]
// ----------------------------------------------------------------------------
// ier_judge
// Frame verdict from held length and captured header fields, plus the
// incrementally updated ICMP checksum for an echo reply.
// ----------------------------------------------------------------------------
module ier_judge
  import ier_pkg::*;
(
  input  logic [CNT_W-1:0] n,
  input  hdr_fields_t      f,
  output judge_t           res
);

  logic [16:0] sum1;
  logic [15:0] sum2;

  always_comb begin
    priority if (n < CNT_W'(MIN_ETH))                res.verdict = VERDICT_DROP;
    else if ({f.etype_hi, f.etype_lo} != ETYPE_IPV4) res.verdict = VERDICT_PASS;
    else if (n < CNT_W'(MIN_IP))                     res.verdict = VERDICT_DROP;
    else if (f.proto != PROTO_ICMP)                  res.verdict = VERDICT_PASS;
    else if (n < CNT_W'(HDR_LEN))                    res.verdict = VERDICT_DROP;
    else if (f.icmp_type != ICMP_TYPE_REQ)           res.verdict = VERDICT_PASS;
    else                                             res.verdict = VERDICT_TX;
  end

  // ~sum + ~old + new, end-around carry, complement. The new word is zero.
  always_comb begin
    sum1 = {1'b0, ~{f.ck_hi, f.ck_lo}} + {1'b0, ~{ICMP_TYPE_REQ, 8'h00}};
    sum2 = sum1[15:0] + {15'd0, sum1[16]};
    res.ck_new = ~(sum2 + {ICMP_TYPE_REPLY, 8'h00});
  end

endmodule

[rtl/ier_checker.sv]
// ----------------------------------------------------------------------------
// ier_checker
// Port-level assertions for the ICMP echo responder, bound to the top level.
// ----------------------------------------------------------------------------
module ier_checker
  import ier_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_end,
  input logic [1:0] out_verdict
);

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // only defined verdict codes leave the block
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == VERDICT_PASS || out_verdict == VERDICT_DROP ||
                   out_verdict == VERDICT_TX))
    else $error("undefined verdict code");

  // every byte of one frame carries the same verdict
  a_verdict_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_end) ##1 out_valid |->
      out_verdict == $past(out_verdict))
    else $error("verdict changed within a frame");

  // a stalled transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(out_end) && $stable(out_verdict)))
    else $error("stalled output changed");

  // a transmit verdict only comes with a frame of at least a full header, never
  // on a lone byte that both starts and ends it
  a_tx_not_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_end) ##1 (out_valid && out_end) |->
      out_verdict != VERDICT_TX)
    else $error("transmit verdict on a one-byte frame");

endmodule

bind icmp_echo_responder ier_checker u_ier_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .out_end     (out_ch.out_end),
  .out_verdict (out_ch.verdict)
);

[tb/tb_icmp_echo_responder.sv]
// ----------------------------------------------------------------------------
// tb_icmp_echo_responder
// Self-checking bench for the ICMP echo responder. Frames are sent byte by
// byte: a few short directed frames, then random frames that are mostly well
// formed echo requests plus truncated, non-IP, non-ICMP and non-echo frames.
// A byte-level predictor works out every output transfer (byte, end mark and
// verdict) and a scoreboard compares each output transfer in order. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_icmp_echo_responder;
  timeunit 1ns;
  timeprecision 1ps;

  import ier_pkg::*;

  localparam int RANDOM_BYTES = 420;  // stop sending random frames after this
  localparam int IDLE_LIMIT   = 2000; // cycles without any transfer
  localparam int TAIL_CYCLES  = 100;  // quiet time after the last result

  // kinds of generated frame
  typedef enum int {
    FR_ECHO,
    FR_NOT_IP,
    FR_NOT_ICMP,
    FR_NOT_ECHO,
    FR_TRUNC
  } frame_kind_t;

  // one expected output transfer
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [1:0] verdict;
  } reply_byte_t;

  // --------------------------------------------------------------------------
  // Predictor and scoreboard of the output byte stream
  // --------------------------------------------------------------------------
  class reply_scoreboard;
    logic [7:0]  hdr[HDR_LEN];   // held header bytes of the current frame
    int          held;           // bytes held; HDR_LEN means streaming
    logic [1:0]  stream_verdict; // verdict applied to streamed bytes
    reply_byte_t expected_q[$];
    int          mismatches;

    function new();
      held           = 0;
      stream_verdict = VERDICT_PASS;
      mismatches     = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    // ones-complement add with end-around carry
    function logic [15:0] fold_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
    endfunction

    function logic [1:0] classify(int n);
      if (n < MIN_ETH) return VERDICT_DROP;
      if ({hdr[IDX_ETYPE_HI], hdr[IDX_ETYPE_LO]} != ETYPE_IPV4) return VERDICT_PASS;
      if (n < MIN_IP) return VERDICT_DROP;
      if (hdr[IDX_PROTO] != PROTO_ICMP) return VERDICT_PASS;
      if (n < HDR_LEN) return VERDICT_DROP;
      if (hdr[IDX_ICMP_TYPE] != ICMP_TYPE_REQ) return VERDICT_PASS;
      return VERDICT_TX;
    endfunction

    function void note_input(logic [7:0] b, logic last);
      logic [7:0]  img[HDR_LEN];
      logic [1:0]  v;
      logic [15:0] ck;
      reply_byte_t r;
      // past the header: straight through with the stored verdict
      if (held >= HDR_LEN) begin
        r.data    = b;
        r.last    = last;
        r.verdict = stream_verdict;
        expected_q.push_back(r);
        if (last) begin
          held           = 0;
          stream_verdict = VERDICT_PASS;
        end
        return;
      end
      hdr[held] = b;
      held++;
      if (held < HDR_LEN && !last) return;

      v   = classify(held);
      img = hdr;
      if (v == VERDICT_TX) begin
        for (int i = 0; i < MAC_LEN; i++) begin
          img[i]           = hdr[MAC_LEN + i];
          img[MAC_LEN + i] = hdr[i];
        end
        for (int i = 0; i < IP_ALEN; i++) begin
          img[IDX_SRC_IP + i] = hdr[IDX_DST_IP + i];
          img[IDX_DST_IP + i] = hdr[IDX_SRC_IP + i];
        end
        img[IDX_ICMP_TYPE] = ICMP_TYPE_REPLY;
        // incremental update: old word echo type, new word reply type
        ck = ~{hdr[IDX_CK_HI], hdr[IDX_CK_LO]};
        ck = fold_add(ck, ~{ICMP_TYPE_REQ, 8'h00});
        ck = fold_add(ck, {ICMP_TYPE_REPLY, 8'h00});
        ck = ~ck;
        img[IDX_CK_HI] = ck[15:8];
        img[IDX_CK_LO] = ck[7:0];
      end
      for (int i = 0; i < held; i++) begin
        r.data    = img[i];
        r.last    = last && (i == held - 1);
        r.verdict = v;
        expected_q.push_back(r);
      end
      if (last) begin
        held           = 0;
        stream_verdict = VERDICT_PASS;
      end else begin
        stream_verdict = v;
      end
    endfunction

    task check_result(logic [7:0] b, logic last, logic [1:0] v);
      reply_byte_t r;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected output byte %02h end %0b verdict %0d", b, last, v));
        return;
      end
      r = expected_q.pop_front();
      if (b !== r.data)
        report($sformatf("out_byte %02h, expected %02h", b, r.data));
      if (last !== r.last)
        report($sformatf("out_end %0b, expected %0b", last, r.last));
      if (v !== r.verdict)
        report($sformatf("verdict %0d, expected %0d", v, r.verdict));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  ier_in_if  in_ch();
  ier_out_if out_ch();

  icmp_echo_responder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  reply_scoreboard sb = new();

  bit         no_idle;       // set for whole frames: back-to-back on both sides
  logic [7:0] frame_bytes[$];
  int         random_sent;

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // One byte transfer, preceded by a random idle gap. valid stays high from
  // one byte to the next when there is no gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.frame_end <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(b, last);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i])
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // hold off the sender until the scoreboard is empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Fill frame_bytes with random content shaped to reach the given verdict
  // path. Fields past the end of a short frame are simply not there.
  task automatic build_frame(input frame_kind_t kind);
    int          len;
    logic [15:0] ck;
    case (kind)
      FR_ECHO:  len = ($urandom_range(0, 3) == 0) ? HDR_LEN
                                                   : HDR_LEN + $urandom_range(1, 10);
      FR_TRUNC: len = $urandom_range(1, HDR_LEN - 1);
      default:  len = $urandom_range(MIN_ETH, HDR_LEN + 12);
    endcase
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));

    if (kind == FR_NOT_IP) begin
      // near miss on the ethertype half the time
      if ($urandom_range(0, 1) == 0) begin
        frame_bytes[IDX_ETYPE_HI] = ETYPE_IPV4[15:8];
        frame_bytes[IDX_ETYPE_LO] = 8'($urandom_range(1, 255));
      end else if ({frame_bytes[IDX_ETYPE_HI], frame_bytes[IDX_ETYPE_LO]} == ETYPE_IPV4) begin
        frame_bytes[IDX_ETYPE_LO] = 8'hFF;
      end
      return;
    end
    if (len > IDX_ETYPE_LO) begin
      frame_bytes[IDX_ETYPE_HI] = ETYPE_IPV4[15:8];
      frame_bytes[IDX_ETYPE_LO] = ETYPE_IPV4[7:0];
    end
    if (len > IDX_PROTO) begin
      if (kind == FR_NOT_ICMP) begin
        if (frame_bytes[IDX_PROTO] == PROTO_ICMP) frame_bytes[IDX_PROTO] = 8'h00;
      end else begin
        frame_bytes[IDX_PROTO] = PROTO_ICMP;
      end
    end
    if (len > IDX_ICMP_TYPE) begin
      if (kind == FR_NOT_ECHO) begin
        if ($urandom_range(0, 1) == 0) frame_bytes[IDX_ICMP_TYPE] = ICMP_TYPE_REPLY;
        else if (frame_bytes[IDX_ICMP_TYPE] == ICMP_TYPE_REQ) frame_bytes[IDX_ICMP_TYPE] = 8'hFF;
      end else if (kind != FR_NOT_ICMP) begin
        frame_bytes[IDX_ICMP_TYPE] = ICMP_TYPE_REQ;
      end
    end
    if (kind == FR_ECHO && $urandom_range(0, 1) == 0) begin
      // checksum corners: all ones, zero, and around the carry of the update
      case ($urandom_range(0, 5))
        0:       ck = 16'hFFFF;
        1:       ck = 16'h0000;
        2:       ck = 16'hF7FF;
        3:       ck = 16'hF800;
        4:       ck = 16'h0800;
        default: ck = 16'h07FF;
      endcase
      frame_bytes[IDX_CK_HI] = ck[15:8];
      frame_bytes[IDX_CK_LO] = ck[7:0];
    end
  endtask

  initial begin
    int pick;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.frame_end <= 1'b0;
    rst_n           <= 1'b0;
    no_idle         = 1'b0;
    random_sent     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one-byte frame, short frame below the Ethernet header,
    // minimal Ethernet frame with a foreign ethertype
    frame_bytes.delete();
    frame_bytes.push_back(8'hFF);
    send_frame();
    frame_bytes.delete();
    repeat (MIN_ETH - 1) frame_bytes.push_back(8'h00);
    send_frame();
    frame_bytes.delete();
    repeat (MIN_ETH) frame_bytes.push_back(8'hFF);
    send_frame();
    drain();

    // random frames, mostly echo requests
    while (random_sent < RANDOM_BYTES) begin
      pick    = $urandom_range(0, 9);
      no_idle = ($urandom_range(0, 3) == 0);
      case (pick)
        6:       build_frame(FR_NOT_IP);
        7:       build_frame(FR_NOT_ICMP);
        8:       build_frame(FR_NOT_ECHO);
        9:       build_frame(FR_TRUNC);
        default: build_frame(FR_ECHO);
      endcase
      send_frame();
      random_sent += frame_bytes.size();
      if ($urandom_range(0, 7) == 0) drain();
    end
    no_idle = 1'b0;

    // end of run: everything predicted has to come out
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random back-pressure, one gap drawn per transfer
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // every output transfer goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(out_ch.out_byte, out_ch.out_end, out_ch.verdict);
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without a transfer on either channel
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d cycles without a transfer, %0d results pending",
               idle_cycles, sb.pending());
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
